>>> hw/rtl/ils_pkg.sv
// Shared constants, codes and control types for the indexed list store.
package ils_pkg;

    localparam int CAPACITY_DEFAULT = 64;

    localparam int OP_W     = 3;
    localparam int POS_W    = 8;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;

    localparam logic [OP_W-1:0] OP_GET      = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_HEAD = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD_TAIL = 3'd2;
    localparam logic [OP_W-1:0] OP_ADD_POS  = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_GET  = 2'd1,
        KIND_INS  = 2'd2,
        KIND_DEL  = 2'd3
    } kind_t;

    typedef struct packed {
        logic latch_in;
        logic eval;
        logic get_rd;
        logic get_cap;
        logic shift_wr;
        logic wr_value;
        logic cnt_dec;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        kind_t dec_kind;
        logic  ins_run;
        logic  shift_more;
        logic  out_free;
    } sts_t;

endpackage

>>> hw/rtl/ils_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rd_data_reg <= mem_reg[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

>>> hw/rtl/ils_datapath.sv
// Datapath: operation decode, entry count, shift index, entry RAM and result register.
module ils_datapath #(
    parameter int CAPACITY = ils_pkg::CAPACITY_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [ils_pkg::OP_W-1:0]            s_operation,
    input  logic signed [ils_pkg::POS_W-1:0]    s_position,
    input  logic signed [ils_pkg::DATA_W-1:0]   s_value,
    input  logic                                m_ready,
    input  ils_pkg::cmd_t                       cmd,
    output ils_pkg::sts_t                       sts,
    output logic                                m_valid,
    output logic signed [ils_pkg::DATA_W-1:0]   m_read_value,
    output logic [ils_pkg::STATUS_W-1:0]        m_status,
    output logic [ils_pkg::LEN_W-1:0]           m_length
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(CAPACITY);
    localparam int CMP_W = (CW > ils_pkg::POS_W - 1) ? CW : ils_pkg::POS_W - 1;

    logic [ils_pkg::OP_W-1:0]     op_reg;
    logic [ils_pkg::POS_W-1:0]    pos_reg;
    logic [ils_pkg::DATA_W-1:0]   value_reg;
    logic [CW-1:0]                count_reg, count_next;
    ils_pkg::kind_t               kind_reg;
    logic [CW-1:0]                slot_reg;
    logic [CW-1:0]                idx_reg, idx_next;
    logic [ils_pkg::STATUS_W-1:0] status_reg;
    logic [ils_pkg::DATA_W-1:0]   rv_reg;
    logic                         out_valid_reg, out_valid_next;
    logic [ils_pkg::DATA_W-1:0]   out_rv_reg;
    logic [ils_pkg::STATUS_W-1:0] out_status_reg;
    logic [ils_pkg::LEN_W-1:0]    out_len_reg;

    // decode
    logic [CMP_W-1:0]             pos_c, cnt_c;
    logic                         pos_neg, in_range, beyond, full;
    logic [CW-1:0]                pos_slot;
    ils_pkg::kind_t               dec_kind;
    logic [CW-1:0]                dec_slot;
    logic [ils_pkg::STATUS_W-1:0] dec_status;
    logic [ils_pkg::DATA_W-1:0]   dec_rv;

    // shift control
    logic [CW:0]                  idx_inc;
    logic [CW-1:0]                src_idx;
    logic                         shift_more;

    // RAM
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr, ram_raddr;
    logic [ils_pkg::DATA_W-1:0]   ram_wdata, ram_rdata;
    logic [CW+ils_pkg::LEN_W-1:0] len_ext;

    assign pos_c    = CMP_W'(pos_reg[ils_pkg::POS_W-2:0]);
    assign cnt_c    = CMP_W'(count_reg);
    assign pos_neg  = pos_reg[ils_pkg::POS_W-1];
    assign in_range = !pos_neg && (pos_c < cnt_c);
    assign beyond   = !pos_neg && (pos_c > cnt_c);
    assign full     = (count_reg == CW'(CAPACITY));
    assign pos_slot = pos_neg ? '0 : CW'(pos_reg[ils_pkg::POS_W-2:0]);

    always_comb begin
        dec_kind   = ils_pkg::KIND_NONE;
        dec_slot   = pos_slot;
        dec_status = ils_pkg::ST_DONE;
        dec_rv     = '0;
        unique case (op_reg)
            ils_pkg::OP_GET: begin
                if (in_range) begin
                    dec_kind = ils_pkg::KIND_GET;
                end else begin
                    dec_status = ils_pkg::ST_RANGE;
                    dec_rv     = '1;
                end
            end
            ils_pkg::OP_ADD_HEAD, ils_pkg::OP_ADD_TAIL, ils_pkg::OP_ADD_POS: begin
                if (op_reg == ils_pkg::OP_ADD_HEAD) begin
                    dec_slot = '0;
                end else if (op_reg == ils_pkg::OP_ADD_TAIL) begin
                    dec_slot = count_reg;
                end
                // range check on a positional add wins over the full check
                if (op_reg == ils_pkg::OP_ADD_POS && beyond) begin
                    dec_status = ils_pkg::ST_RANGE;
                end else if (full) begin
                    dec_status = ils_pkg::ST_FULL;
                end else begin
                    dec_kind = ils_pkg::KIND_INS;
                end
            end
            ils_pkg::OP_DELETE: begin
                if (in_range) begin
                    dec_kind = ils_pkg::KIND_DEL;
                end else begin
                    dec_status = ils_pkg::ST_RANGE;
                end
            end
            default: begin
                dec_kind = ils_pkg::KIND_NONE;
            end
        endcase
    end

    // insert walks the destination down from the tail, delete walks it up from the hole
    assign idx_inc    = {1'b0, idx_reg} + (CW+1)'(1);
    assign src_idx    = (kind_reg == ils_pkg::KIND_INS) ? idx_reg - CW'(1) : idx_inc[CW-1:0];
    assign shift_more = (kind_reg == ils_pkg::KIND_INS) ? (idx_reg != slot_reg)
                                                         : (idx_inc < {1'b0, count_reg});

    always_comb begin
        idx_next = idx_reg;
        if (cmd.eval) begin
            idx_next = (dec_kind == ils_pkg::KIND_INS) ? count_reg : dec_slot;
        end else if (cmd.shift_wr) begin
            idx_next = (kind_reg == ils_pkg::KIND_INS) ? src_idx : idx_inc[CW-1:0];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.wr_value) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.cnt_dec) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign ram_we    = cmd.shift_wr || cmd.wr_value;
    assign ram_waddr = idx_reg[AW-1:0];
    assign ram_wdata = cmd.wr_value ? value_reg : ram_rdata;
    assign ram_raddr = cmd.get_rd ? slot_reg[AW-1:0] : src_idx[AW-1:0];
    assign len_ext   = {{ils_pkg::LEN_W{1'b0}}, count_reg};

    ils_ram #(
        .WIDTH (ils_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= ils_pkg::KIND_NONE;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cmd.eval) begin
                kind_reg <= dec_kind;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (cmd.latch_in) begin
            op_reg    <= s_operation;
            pos_reg   <= s_position;
            value_reg <= s_value;
        end
        if (cmd.eval) begin
            slot_reg   <= dec_slot;
            status_reg <= dec_status;
            rv_reg     <= dec_rv;
        end else if (cmd.get_cap) begin
            rv_reg <= ram_rdata;
        end
        if (cmd.load_out) begin
            out_rv_reg     <= rv_reg;
            out_status_reg <= status_reg;
            out_len_reg    <= len_ext[ils_pkg::LEN_W-1:0];
        end
    end

    assign sts.dec_kind   = dec_kind;
    assign sts.ins_run    = (kind_reg == ils_pkg::KIND_INS);
    assign sts.shift_more = shift_more;
    assign sts.out_free   = !out_valid_reg || m_ready;

    assign m_valid      = out_valid_reg;
    assign m_read_value = out_rv_reg;
    assign m_status     = out_status_reg;
    assign m_length     = out_len_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!out_valid_reg || m_ready))
        else $error("result register overwritten while still pending");

    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_value |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not advance the entry count by one");

    a_write_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.shift_wr || cmd.wr_value) |-> (idx_reg < CW'(CAPACITY)))
        else $error("entry write outside the store");
`endif

endmodule

>>> hw/rtl/ils_ctrl.sv
// Controller: sequences accept, decode, get read, shift walk, insert write and result load.
module ils_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  ils_pkg::sts_t sts,
    output ils_pkg::cmd_t cmd
);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_EVAL     = 8'b0000_0010,
        ST_GET_RD   = 8'b0000_0100,
        ST_GET_CAP  = 8'b0000_1000,
        ST_LOOP     = 8'b0001_0000,
        ST_SHIFT_WR = 8'b0010_0000,
        ST_WRITE    = 8'b0100_0000,
        ST_FINISH   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.latch_in = s_valid;
                if (s_valid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
                unique case (sts.dec_kind)
                    ils_pkg::KIND_GET: state_next = ST_GET_RD;
                    ils_pkg::KIND_INS: state_next = ST_LOOP;
                    ils_pkg::KIND_DEL: state_next = ST_LOOP;
                    default:           state_next = ST_FINISH;
                endcase
            end
            ST_GET_RD: begin
                cmd.get_rd = 1'b1;
                state_next = ST_GET_CAP;
            end
            ST_GET_CAP: begin
                cmd.get_cap = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_LOOP: begin
                // source entry read is issued here; move it next cycle
                if (sts.shift_more) begin
                    state_next = ST_SHIFT_WR;
                end else if (sts.ins_run) begin
                    state_next = ST_WRITE;
                end else begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = ST_FINISH;
                end
            end
            ST_SHIFT_WR: begin
                cmd.shift_wr = 1'b1;
                state_next   = ST_LOOP;
            end
            ST_WRITE: begin
                cmd.wr_value = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FINISH: begin
                // hold until the result register is free
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/indexed_list_store.sv
// Top level of the indexed list store: controller, datapath and handshake ports.
// An insert or a delete moves N entries (up to CAPACITY-1) one at a time, a get reads one entry,
// and a rejected transaction or a no-op goes straight from decode to the result load.
// Throughput: one transaction at a time; the next is accepted in the cycle after the result is
// loaded, and the load waits while the previous result is still pending on m_ready.
// Reset: synchronous active-low aresetn empties the list; the entry RAM is not cleared.
module indexed_list_store #(
    parameter int CAPACITY = ils_pkg::CAPACITY_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ils_pkg::OP_W-1:0]          s_operation,
    input  logic signed [ils_pkg::POS_W-1:0]  s_position,
    input  logic signed [ils_pkg::DATA_W-1:0] s_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [ils_pkg::DATA_W-1:0] m_read_value,
    output logic [ils_pkg::STATUS_W-1:0]      m_status,
    output logic [ils_pkg::LEN_W-1:0]         m_length
);

    ils_pkg::cmd_t cmd;
    ils_pkg::sts_t sts;

    ils_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ils_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_operation  (s_operation),
        .s_position   (s_position),
        .s_value      (s_value),
        .m_ready      (m_ready),
        .cmd          (cmd),
        .sts          (sts),
        .m_valid      (m_valid),
        .m_read_value (m_read_value),
        .m_status     (m_status),
        .m_length     (m_length)
    );

endmodule
